@@ src/periodic_task_dispatcher_top_assert.svh @@
// Assertion macros shared by the dispatcher.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTD_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("dispatcher assertion failed");

// Next-cycle implication, checked outside reset.
`define PTD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("dispatcher assertion failed");

`endif

@@ src/ptd_pkg.sv @@
package ptd_pkg;

	localparam int NUM_SLOTS    = 8;
	localparam int PERIOD_W     = 16;
	localparam int CNT_W        = 32;
	localparam int TICK_W       = 16;
	localparam int SEL_W        = 3;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 5;
	localparam int REG_IDX_W    = 3;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_QUICK   = 1'b1;

	typedef logic [NUM_SLOTS-1:0][PERIOD_W-1:0] period_arr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_EMIT
	} ptd_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic quick;
		logic capture;
		logic add_step;
		logic emit_step;
	} ptd_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_quick;
		logic ticks_zero;
		logic at_end;
		logic due;
		logic out_free;
	} ptd_sts_t;

endpackage

@@ src/ptd_in_if.sv @@
interface ptd_in_if;
	import ptd_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [TICK_W-1:0] elapsed_ticks;
	logic [SEL_W-1:0]  task_select;

	modport source (output valid, cmd, elapsed_ticks, task_select, input ready);
	modport sink (input valid, cmd, elapsed_ticks, task_select, output ready);

endinterface

@@ src/ptd_out_if.sv @@
interface ptd_out_if;
	import ptd_pkg::*;

	logic             valid;
	logic             ready;
	logic [SEL_W-1:0] due_task;
	logic             late;
	logic [CNT_W-1:0] late_by;
	logic             last;

	modport source (output valid, due_task, late, late_by, last, input ready);
	modport sink (input valid, due_task, late, late_by, last, output ready);

endinterface

@@ src/periodic_task_dispatcher_top.sv @@
// Periodic task dispatcher. Each task has a 32-bit elapsed counter and a
// 16-bit period register (APB, task i at byte address 4*i, reset 1000). An
// advance item adds its tick count to every counter, saturating, and then
// reports every task that has reached its period, in index order, clearing
// its counter; the final report of an advance carries last. A quick call
// loads one task's counter with its period. An advance with nonzero ticks
// occupies the block after it is accepted: one pass that updates one counter
// per cycle, then one pass that reports one task per cycle, a due report
// waiting while the output register cannot take it. A quick call or an
// advance of zero ticks completes in the cycle in which it is accepted.
`include "periodic_task_dispatcher_top_assert.svh"

module periodic_task_dispatcher_top
	import ptd_pkg::*;
#(
	parameter int TASK_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ptd_in_if.sink                in_ch,
	ptd_out_if.source             out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	period_arr_t          period_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_write;
	logic                 in_ready;
	ptd_cmd_t             cmd;
	ptd_sts_t             sts;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[APB_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = APB_DATA_W'(period_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				period_q[i] <= PERIOD_RESET;
			end
		end else if (cfg_write) begin
			period_q[reg_idx] <= pwdata[PERIOD_W-1:0];
		end
	end

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_datapath #(
		.TASK_COUNT (TASK_COUNT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_cmd           (in_ch.cmd),
		.in_elapsed_ticks (in_ch.elapsed_ticks),
		.in_task_select   (in_ch.task_select),
		.periods          (period_q),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_due_task     (out_ch.due_task),
		.out_late         (out_ch.late),
		.out_late_by      (out_ch.late_by),
		.out_last         (out_ch.last)
	);

	assign in_ch.ready = in_ready;

	// An item is late exactly when it has a nonzero overrun.
	`PTD_ASSERT_IMP(a_late_matches_overrun, clk, arst_n, out_ch.valid,
		out_ch.late == (out_ch.late_by != '0))
	// A real advance keeps the block busy for its walk.
	`PTD_ASSERT_NEXT(a_advance_goes_busy, clk, arst_n,
		in_ch.valid && in_ready && in_ch.cmd == CMD_ADVANCE && in_ch.elapsed_ticks != '0,
		!in_ready)
	// A quick call finishes in the cycle it is accepted.
	`PTD_ASSERT_NEXT(a_quick_single_cycle, clk, arst_n,
		in_ch.valid && in_ready && in_ch.cmd == CMD_QUICK, in_ready)

endmodule

@@ src/ptd_ctrl.sv @@
module ptd_ctrl
	import ptd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ptd_sts_t sts,
	output ptd_cmd_t cmd
);

	ptd_state_t state_q;
	ptd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !sts.in_quick && !sts.ticks_zero) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (sts.at_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.at_end && (!sts.due || sts.out_free)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.quick   = in_valid && sts.in_quick;
				cmd.capture = in_valid && !sts.in_quick && !sts.ticks_zero;
			end
			ST_ADD: begin
				cmd.add_step = 1'b1;
			end
			ST_EMIT: begin
				// A due task waits until the output register can take its item.
				cmd.emit_step = !sts.due || sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ src/ptd_datapath.sv @@
module ptd_datapath
	import ptd_pkg::*;
#(
	parameter int TASK_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_cmd,
	input  logic [TICK_W-1:0] in_elapsed_ticks,
	input  logic [SEL_W-1:0]  in_task_select,
	input  period_arr_t       periods,
	input  ptd_cmd_t          cmd,
	output ptd_sts_t          sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SEL_W-1:0]  out_due_task,
	output logic              out_late,
	output logic [CNT_W-1:0]  out_late_by,
	output logic              out_last
);

	localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	logic [CNT_W-1:0]    counter_q [TASK_COUNT];
	logic [TASK_COUNT-1:0] due_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [IDX_W-1:0]    idx_q;

	logic                out_valid_q;
	logic [SEL_W-1:0]    due_task_q;
	logic                late_q;
	logic [CNT_W-1:0]    late_by_q;
	logic                last_q;

	logic                sel_ok;
	logic [IDX_W-1:0]    rd_idx;
	logic [PERIOD_W-1:0] period_sel;
	logic [CNT_W-1:0]    count_sel;
	logic [CNT_W:0]      sum;
	logic [CNT_W-1:0]    sum_sat;
	logic                at_end;
	logic                more_due;
	logic                emit_load;

	assign sel_ok     = (int'(in_task_select) < TASK_COUNT);
	assign rd_idx     = cmd.quick ? IDX_W'(in_task_select) : idx_q;
	assign period_sel = periods[rd_idx];
	assign count_sel  = counter_q[rd_idx];
	assign sum        = {1'b0, count_sel} + (CNT_W + 1)'(ticks_q);
	assign sum_sat    = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	assign at_end     = (idx_q == IDX_W'(TASK_COUNT - 1));
	assign emit_load  = cmd.emit_step && due_q[idx_q];

	// Last mark: no due task remains above the current index.
	always_comb begin
		more_due = 1'b0;
		for (int j = 0; j < TASK_COUNT; j++) begin
			if (j > int'(idx_q) && due_q[j]) begin
				more_due = 1'b1;
			end
		end
	end

	always_comb begin
		sts.in_quick   = (in_cmd == CMD_QUICK);
		sts.ticks_zero = (in_elapsed_ticks == '0);
		sts.at_end     = at_end;
		sts.due        = due_q[idx_q];
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				counter_q[i] <= '0;
			end
			due_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.quick && sel_ok) begin
				counter_q[rd_idx] <= CNT_W'(period_sel);
			end
			if (cmd.add_step) begin
				counter_q[idx_q] <= sum_sat;
				due_q[idx_q]     <= (sum_sat >= CNT_W'(period_sel));
			end
			if (emit_load) begin
				counter_q[idx_q] <= '0;
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.add_step || cmd.emit_step) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ticks_q <= in_elapsed_ticks;
		end
		if (emit_load) begin
			due_task_q <= SEL_W'(idx_q);
			late_q     <= (count_sel != CNT_W'(period_sel));
			late_by_q  <= count_sel - CNT_W'(period_sel);
			last_q     <= !more_due;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_due_task = due_task_q;
	assign out_late     = late_q;
	assign out_late_by  = late_by_q;
	assign out_last     = last_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import ptd_pkg::*;

	localparam int TASK_COUNT = 8;
	// An advance walks the counters and then the reports, one task per cycle unless a due report is held back.
	localparam int SETTLE = 2 * TASK_COUNT + 8;
	localparam int LONG_HOLD = 80;
	localparam int RAND_PHASES = 4;
	localparam int ITEMS_PER_PHASE = 46;
	localparam int PLAN_LEN = 27;

	typedef struct packed {
		logic [SEL_W-1:0] due_task;
		logic             late;
		logic [CNT_W-1:0] late_by;
		logic             last;
	} due_rpt_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_PERIODS
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 cmd;
		logic [TICK_W-1:0]    ticks;
		logic [SEL_W-1:0]     sel;
		logic [PERIOD_W-1:0]  period;
		logic                 typed;
		logic [NUM_SLOTS-1:0] due_mask;
		logic [CNT_W-1:0]     overrun;
	} plan_row_t;

	// Typed rows list the due tasks as a mask; all of them share one overrun.
	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_ITEM,    CMD_ADVANCE, 16'd0,     3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd999,   3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'hFF, 32'd0},
		'{ROW_ITEM,    CMD_QUICK,   16'd0,     3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_QUICK,   16'd0,     3'd7, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'h81, 32'd1},
		'{ROW_ITEM,    CMD_ADVANCE, 16'hFFFF,  3'd0, 16'd0,     1'b0, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_QUICK,   16'd0,     3'd3, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd0,     3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'h08, 32'd1},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd998,   3'd0, 16'd0,     1'b0, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'hF7, 32'd0},
		'{ROW_ITEM,    CMD_QUICK,   16'hA5A5,  3'd5, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'h5A5A,  3'd6, 16'd0,     1'b0, 8'h00, 32'd0},
		'{ROW_PERIODS, CMD_ADVANCE, 16'd0,     3'd0, 16'd0,     1'b0, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd7,     3'd0, 16'd0,     1'b1, 8'hFF, 32'd7},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'hFF, 32'd1},
		'{ROW_ITEM,    CMD_QUICK,   16'd0,     3'd2, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd0,     3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'hFFFF,  3'd0, 16'd0,     1'b1, 8'hFF, 32'd65535},
		'{ROW_PERIODS, CMD_ADVANCE, 16'd0,     3'd0, 16'hFFFF,  1'b0, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'hFFFF,  3'd0, 16'd0,     1'b1, 8'hFF, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'hFFFE,  3'd0, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'hFFFF,  3'd0, 16'd0,     1'b1, 8'hFF, 32'd65534},
		'{ROW_ITEM,    CMD_QUICK,   16'd0,     3'd4, 16'd0,     1'b1, 8'h00, 32'd0},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd1,     3'd0, 16'd0,     1'b1, 8'h10, 32'd1},
		'{ROW_ITEM,    CMD_ADVANCE, 16'd2,     3'd0, 16'd0,     1'b0, 8'h00, 32'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ptd_in_if  in_ch ();
	ptd_out_if out_ch ();

	periodic_task_dispatcher_top #(
		.TASK_COUNT(TASK_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [CNT_W-1:0]    tick_count [TASK_COUNT];
	logic [PERIOD_W-1:0] period_shadow [NUM_SLOTS];
	due_rpt_t            pending_due [$];
	due_rpt_t            model_due [$];
	due_rpt_t            table_due [$];
	bit                  cur_typed;
	bit                  calm;
	bit                  stall_req;
	int                  n_err;
	int                  n_items;
	int                  n_quick;
	int                  n_reports;
	int                  n_late;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	// Adds the ticks to every counter and lists the tasks that come due; a quick call reloads one counter.
	function automatic void predict_dispatch(input logic cmd, input logic [TICK_W-1:0] ticks,
			input logic [SEL_W-1:0] sel);
		logic [CNT_W:0]   sum;
		logic [CNT_W-1:0] cnt;
		due_rpt_t         r;
		model_due.delete();
		if (cmd == CMD_QUICK) begin
			if (sel < TASK_COUNT)
				tick_count[sel] = CNT_W'(period_shadow[sel]);
		end else if (ticks != '0) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				sum = {1'b0, tick_count[i]} + (CNT_W + 1)'(ticks);
				cnt = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
				if (cnt >= CNT_W'(period_shadow[i])) begin
					r.due_task = SEL_W'(i);
					r.late = (cnt != CNT_W'(period_shadow[i]));
					r.late_by = cnt - CNT_W'(period_shadow[i]);
					r.last = 1'b0;
					model_due.push_back(r);
					cnt = '0;
				end
				tick_count[i] = cnt;
			end
			if (model_due.size() > 0) begin
				r = model_due.pop_back();
				r.last = 1'b1;
				model_due.push_back(r);
			end
		end
	endfunction

	always @(posedge clk) begin
		due_rpt_t got;
		due_rpt_t want;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.due_task, out_ch.late, out_ch.late_by, out_ch.last};
			n_reports++;
			if (got.late)
				n_late++;
			if (pending_due.size() == 0) begin
				$error("due report for task %0d with none expected", got.due_task);
				n_err++;
			end else begin
				want = pending_due.pop_front();
				if (got.due_task !== want.due_task) begin
					$error("due_task: expected %0d, got %0d", want.due_task, got.due_task);
					n_err++;
				end
				if (got.late !== want.late) begin
					$error("late: expected %0d, got %0d", want.late, got.late);
					n_err++;
				end
				if (got.late_by !== want.late_by) begin
					$error("late_by: expected %0d, got %0d", want.late_by, got.late_by);
					n_err++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, got.last);
					n_err++;
				end
			end
		end
		if (in_ch.valid && in_ch.ready) begin
			n_items++;
			if (in_ch.cmd == CMD_QUICK)
				n_quick++;
			predict_dispatch(in_ch.cmd, in_ch.elapsed_ticks, in_ch.task_select);
			if (cur_typed) begin
				foreach (table_due[k])
					pending_due.push_back(table_due[k]);
			end else begin
				foreach (model_due[k])
					pending_due.push_back(model_due[k]);
			end
		end
	end

	// Result side: short random stalls, and one long hold when asked for.
	initial begin
		int burst;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ch.ready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				stall_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 7);
				out_ch.ready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic cmd, input logic [TICK_W-1:0] ticks,
			input logic [SEL_W-1:0] sel, input bit typed);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_typed = typed;
		in_ch.valid = 1'b1;
		in_ch.cmd = cmd;
		in_ch.elapsed_ticks = ticks;
		in_ch.task_select = sel;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (pending_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Writes one period register and reads it back.
	task automatic write_period(input int idx, input logic [PERIOD_W-1:0] val);
		logic [APB_DATA_W-1:0] rd;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_ADDR_W'(4 * idx);
		pwdata = $urandom;
		pwdata[PERIOD_W-1:0] = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		period_shadow[idx] = val;
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (rd !== APB_DATA_W'(val)) begin
			$error("period_%0d: expected %0d, got %0d", idx, val, rd);
			n_err++;
		end
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PERIOD_W'($urandom);
			default: return PERIOD_W'($urandom_range(1, 60));
		endcase
	endfunction

	initial begin
		logic [TICK_W-1:0] ticks;
		logic              cmd;
		due_rpt_t          r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_ADVANCE;
		in_ch.elapsed_ticks = '0;
		in_ch.task_select = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			period_shadow[i] = PERIOD_RESET;
		for (int i = 0; i < TASK_COUNT; i++)
			tick_count[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].kind == ROW_PERIODS) begin
				wait_drained();
				for (int t = 0; t < NUM_SLOTS; t++)
					write_period(t, plan[k].period);
			end else begin
				table_due.delete();
				for (int t = 0; t < NUM_SLOTS; t++) begin
					if (plan[k].due_mask[t])
						table_due.push_back('{SEL_W'(t), plan[k].overrun != 0,
							plan[k].overrun, 1'b0});
				end
				if (table_due.size() > 0) begin
					r = table_due.pop_back();
					r.last = 1'b1;
					table_due.push_back(r);
				end
				send_item(plan[k].cmd, plan[k].ticks, plan[k].sel, plan[k].typed);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			for (int t = 0; t < NUM_SLOTS; t++)
				write_period(t, pick_period());
			calm = (ph == RAND_PHASES - 1);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Hold the result side long enough that the input stalls.
				if (ph == 1 && k == 10)
					stall_req = 1'b1;
				if (ph == 2 && k == 20)
					wait_drained();
				cmd = ($urandom_range(0, 4) == 0) ? CMD_QUICK : CMD_ADVANCE;
				case ($urandom_range(0, 19))
					0: ticks = '0;
					1, 2: ticks = TICK_W'($urandom);
					default: ticks = TICK_W'($urandom_range(1, 40));
				endcase
				send_item(cmd, ticks, SEL_W'($urandom_range(0, 7)), 1'b0);
			end
		end

		in_ch.valid = 1'b0;
		while (pending_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d items (%0d quick calls) over seven period settings.", n_items, n_quick);
		$display("Checked %0d due reports, %0d of them late; %0d mismatches.",
			n_reports, n_late, n_err);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/ptd_pkg.sv
src/ptd_in_if.sv
src/ptd_out_if.sv
src/ptd_ctrl.sv
src/ptd_datapath.sv
src/periodic_task_dispatcher_top.sv
tb/sv/tb.sv
